@@ src/brl_pkg.sv @@
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants for the block RMS level core and its checker.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned SQ_W        = 31;               // 32768^2 fits 31 bits
  localparam int unsigned SUM_W       = 47;
  localparam int unsigned DVD_W       = SUM_W + 2 * FRAC_BITS;
  localparam int unsigned ROOT_W      = 24;
  localparam int unsigned REM_W       = ROOT_W + 3;       // shared remainder
  localparam int unsigned STEP_W      = $clog2(DVD_W);

  localparam logic [CNT_W-1:0]  CntMax   = CNT_W'(MAX_SAMPLES);
  localparam logic [STEP_W-1:0] DivLast  = STEP_W'(DVD_W - 1);
  localparam logic [STEP_W-1:0] SqrtLast = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] SumTop   = STEP_W'(SUM_W);

  typedef struct packed {
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic       last_sample;
  } brl_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rms_level;
    logic [CNT_W-1:0]  sample_count;
    logic              count_overflow;
  } brl_out_t;

  typedef enum logic [2:0] {
    BRL_IDLE,
    BRL_DRAIN,
    BRL_DIV,
    BRL_SQRT,
    BRL_DONE
  } brl_state_e;

endpackage

@@ src/block_rms_level_core.sv @@
// ----------------------------------------------------------------------------
// block_rms_level_core
// Sum of squares of 16-bit PCM samples; on the last sample of a block emits
// floor(sqrt(floor(sum * 2^16 / count))) as unsigned Q8 with the count.
// ----------------------------------------------------------------------------
//  channel   ports                      transaction taken when
//  input     start, in_i, busy          start high and busy low
//  result    valid_o, res_o             valid_o high (one cycle, no stall)
//
//  Samples stream in at one per cycle while busy is low.
//  After a last sample the core stays busy through a drain state folding in
//  the final square, 63 divide and 24 root steps on one shared subtractor,
//  and a done state with valid_o high. Reset clears the sum, count and flag.
//  The result cannot be held off; it is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module block_rms_level_core
  import brl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  brl_in_t  in_i,
  output logic     valid_o,
  output brl_out_t res_o
);

  brl_state_e state_q, state_d;

  logic [DVD_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic              pend_q, pend_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic              accept;
  logic              room;
  logic [MAG_W-1:0]  raw;
  logic [MAG_W-1:0]  mag;
  logic [2*MAG_W-1:0] prod;
  logic [DVD_W-1:0]  acc_sum;

  // shared subtract/compare unit
  logic [REM_W-1:0]  sub_a, sub_b;
  logic [REM_W:0]    diff;
  logic              ge;
  logic              feed;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      BRL_IDLE:  if (accept && in_i.last_sample) state_d = BRL_DRAIN;
      BRL_DRAIN: state_d = BRL_DIV;
      BRL_DIV:   if (step_q == DivLast) state_d = BRL_SQRT;
      BRL_SQRT:  if (step_q == SqrtLast) state_d = BRL_DONE;
      BRL_DONE:  state_d = BRL_IDLE;
      default:   state_d = BRL_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    busy    = 1'b1;
    valid_o = 1'b0;
    case (state_q)
      BRL_IDLE: busy    = 1'b0;
      BRL_DONE: valid_o = 1'b1;
      default:  busy    = 1'b1;
    endcase
  end

  assign res_o.rms_level      = root_q;
  assign res_o.sample_count   = cnt_q;
  assign res_o.count_overflow = ovf_q;

  // ---------------- datapath ----------------
  assign accept = start && !busy;
  assign room   = (cnt_q != CntMax);
  assign raw    = {in_i.high_byte, in_i.low_byte};
  assign mag    = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
  assign prod   = mag * mag;

  assign acc_sum = acc_q + DVD_W'(sq_q);

  // dividend is acc << 16: sum bits first, then zeros
  assign feed = (step_q < SumTop) ? acc_q[SUM_W-1] : 1'b0;

  always_comb begin
    if (state_q == BRL_SQRT) begin
      sub_a = {rem_q[REM_W-3:0], acc_q[2*ROOT_W-1 -: 2]};
      sub_b = {1'b0, root_q, 2'b01};
    end else begin
      sub_a = {{(REM_W-CNT_W-1){1'b0}}, rem_q[CNT_W-1:0], feed};
      sub_b = {{(REM_W-CNT_W){1'b0}}, cnt_q};
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = !diff[REM_W];

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    sq_d   = SQ_W'(prod);
    pend_d = 1'b0;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;

    // square of the previous sample is registered, then folded into the sum
    if (pend_q) acc_d = acc_sum;

    if (accept) begin
      if (room) begin
        cnt_d  = cnt_q + CNT_W'(1);
        pend_d = 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    case (state_q)
      BRL_DRAIN: begin
        step_d = '0;
        rem_d  = '0;
      end
      BRL_DIV: begin
        acc_d = {acc_q[DVD_W-2:0], ge};
        rem_d = ge ? diff[REM_W-1:0] : sub_a;
        if (step_q == DivLast) begin
          step_d = '0;
          rem_d  = '0;
          root_d = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      BRL_SQRT: begin
        acc_d  = {acc_q[DVD_W-3:0], 2'b00};
        rem_d  = ge ? diff[REM_W-1:0] : sub_a;
        root_d = {root_q[ROOT_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
      end
      BRL_DONE: begin
        acc_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BRL_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

@@ src/brl_checker.sv @@
// ----------------------------------------------------------------------------
// brl_checker
// Port-level checks on the block RMS level core, bound to every core instance.
// ----------------------------------------------------------------------------
module brl_checker
  import brl_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input brl_in_t  in_i,
  input logic     valid_o,
  input brl_out_t res_o
);

  // a last-sample transaction puts the core to work
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.last_sample |=> busy)
    else $error("core not busy after last sample");

  // results come only while busy, never from the idle state
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result shown while idle");

  // after a result the core is ready again
  a_valid_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy && !valid_o)
    else $error("core did not return to idle after result");

  // every result covers at least one sample
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.sample_count != '0)
    else $error("result with zero sample count");

endmodule

bind block_rms_level_core brl_checker u_brl_checker (.*);

@@ tb/brl_level_checker.sv @@
// ----------------------------------------------------------------------------
// brl_level_checker
// Watches the sample and result channels of block_rms_level_core. It keeps
// its own running sum of squares and sample count, predicts the RMS level of
// each block, and compares every result field by field with the oldest
// prediction. It hands the mismatch count and open predictions to the top.
// ----------------------------------------------------------------------------
module brl_level_checker
  import brl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  brl_in_t  in_i,
  input  logic     valid_o,
  input  brl_out_t res_o,
  output int       fail_cnt_o,
  output int       pending_o
);

  longint unsigned sq_sum;
  longint unsigned seen_cnt;
  logic            dropped;
  brl_out_t        level_q[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Fold one sample into the block; on the last sample produce the level.
  task automatic absorb_sample(input brl_in_t s, output bit done, output brl_out_t lvl);
    logic [15:0]     raw;
    longint unsigned mag;
    longint unsigned scaled;
    longint unsigned root;
    raw  = {s.high_byte, s.low_byte};
    mag  = raw[15] ? 64'd65536 - 64'(raw) : 64'(raw);
    done = 1'b0;
    lvl  = '0;
    if (seen_cnt < MAX_SAMPLES) begin
      sq_sum   += mag * mag;
      seen_cnt += 1;
    end else begin
      dropped = 1'b1;
    end
    if (s.last_sample) begin
      if (seen_cnt == 0) begin
        root = 0;
      end else begin
        scaled = (sq_sum << (2 * FRAC_BITS)) / seen_cnt;
        root   = floor_root(scaled);
      end
      if (root > 64'hFF_FFFF) root = 64'hFF_FFFF;
      lvl.rms_level      = root[ROOT_W-1:0];
      lvl.sample_count   = seen_cnt[CNT_W-1:0];
      lvl.count_overflow = dropped;
      done     = 1'b1;
      sq_sum   = 0;
      seen_cnt = 0;
      dropped  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int       fails;
    bit       popped;
    bit       pushed;
    brl_out_t want;
    brl_out_t lvl;
    if (!rst_ni) begin
      sq_sum     = 0;
      seen_cnt   = 0;
      dropped    = 1'b0;
      level_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      fails  = 0;
      popped = 1'b0;
      pushed = 1'b0;
      if (valid_o) begin
        if (level_q.size() == 0) begin
          $error("result with no block pending: rms_level %0d sample_count %0d",
                 res_o.rms_level, res_o.sample_count);
          fails++;
        end else begin
          want   = level_q.pop_front();
          popped = 1'b1;
          if (res_o.rms_level !== want.rms_level) begin
            $error("rms_level: expected %0d, actual %0d", want.rms_level, res_o.rms_level);
            fails++;
          end
          if (res_o.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, actual %0d",
                   want.sample_count, res_o.sample_count);
            fails++;
          end
          if (res_o.count_overflow !== want.count_overflow) begin
            $error("count_overflow: expected %0d, actual %0d",
                   want.count_overflow, res_o.count_overflow);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        absorb_sample(in_i, pushed, lvl);
        if (pushed) level_q.push_back(lvl);
      end
      fail_cnt_o <= fail_cnt_o + fails;
      pending_o  <= pending_o + int'(pushed) - int'(popped);
    end
  end

endmodule

@@ tb/tb_block_rms_level_core.sv @@
// ----------------------------------------------------------------------------
// tb_block_rms_level_core
// Drives blocks of PCM samples into block_rms_level_core: directed extremes,
// then random blocks under several sender idle patterns. The checker
// predicts and compares results.
// ----------------------------------------------------------------------------
module tb_block_rms_level_core;
  import brl_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseItems = 440;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  brl_in_t  in_i;
  logic     valid_o;
  brl_out_t res_o;
  int       fail_cnt;
  int       pending;

  int       idle_pct;
  int       quiet_left;
  int       cycle_cnt;

  block_rms_level_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  brl_level_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .valid_o    (valid_o),
    .res_o      (res_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("block_rms_level_core test failed");
    $finish;
  end

  // One sample transaction; optional idle gap before it.
  task automatic send_sample(input logic [15:0] smp, input logic last);
    int      gap;
    brl_in_t item;
    gap = 0;
    if (quiet_left > 0) quiet_left--;
    else while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.low_byte    = smp[7:0];
    item.high_byte   = smp[15:8];
    item.last_sample = last;
    start <= 1'b1;
    in_i  <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off until every predicted level has come back.
  task automatic wait_levels_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] s;
    case ($urandom_range(9))
      0: s = 16'h8000;
      1: s = 16'h7FFF;
      2: s = 16'h0000;
      3: s = 16'hFFFF;
      4: s = 16'($signed($urandom_range(0, 31)) - 16);
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  initial begin
    int pct[3];
    int len;
    int sent;
    pct        = '{0, 63, 35};
    idle_pct   = 0;
    quiet_left = 0;
    start      <= 1'b0;
    in_i       <= '0;
    rst_ni     <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample blocks at the extremes
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h00FF, 1'b1);
    send_sample(16'hFF00, 1'b1);
    // short mixed blocks
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0002, 1'b0);
    send_sample(16'h0003, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    wait_levels_drained();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pct[ph];
      sent     = 0;
      while (sent < PhaseItems) begin
        case ($urandom_range(19))
          0:       len = $urandom_range(65, 300);
          1, 2, 3: len = $urandom_range(9, 64);
          default: len = $urandom_range(1, 8);
        endcase
        if ($urandom_range(9) == 0) quiet_left = $urandom_range(10, 30);
        send_block(len);
        sent += len;
      end
      wait_levels_drained();
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("block_rms_level_core test passed");
    end else begin
      $display("block_rms_level_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/brl_pkg.sv
src/block_rms_level_core.sv
src/brl_checker.sv
tb/brl_level_checker.sv
tb/tb_block_rms_level_core.sv
